// ===== hdl/vwap_pkg.sv =====
// Shared types and codes for the per-symbol VWAP accumulator.
package vwap_pkg;

  typedef enum logic {
    OP_TRADE = 1'b0,
    OP_QUERY = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    ST_HIT  = 2'd0,
    ST_NEW  = 2'd1,
    ST_FULL = 2'd2,
    ST_MISS = 2'd3
  } status_t;

  typedef struct packed {
    opcode_t     opcode;
    logic [63:0] symbol;
    logic [31:0] price;
    logic [31:0] quantity;
  } in_word_t;

  typedef struct packed {
    status_t     status;
    logic [63:0] sum_price_qty;
    logic [63:0] total_qty;
    logic [31:0] trade_count;
    logic        saturated;
  } out_word_t;

  // One table row of running totals.
  typedef struct packed {
    logic [63:0] sum;
    logic [63:0] qty;
    logic [31:0] cnt;
  } row_t;

endpackage

// ===== hdl/vwap_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module vwap_ram #(
  parameter int WIDTH = 160,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hdl/per_symbol_vwap_accumulator_top.sv =====
// Per-symbol VWAP accumulator: a symbol table of ENTRIES rows, each holding the
// running sum of price*quantity, total quantity and trade count, all clamped at
// their maximum. A trade word adds to its symbol's row, or claims the lowest free
// row, or reports the table full; a query word returns the row or reports not
// found. One word is accepted per clock when nothing stalls, and its result word
// goes through a key-compare stage over all rows that also issues the totals RAM
// read, a stage that takes the registered read data and updates the row, and the
// output register. A stalled result holds every stage behind it. Row keys sit in
// flip-flops so every row is compared in the same cycle; the valid bits clear
// at reset and no other clearing is needed.
module per_symbol_vwap_accumulator_top
  import vwap_pkg::*;
#(
  parameter int ENTRIES = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int ROW_W = $bits(row_t);

  // Pipeline control.
  logic a_valid_r, a_valid_nxt;
  logic b_valid_r, b_valid_nxt;
  logic out_valid_r, out_valid_nxt;
  logic in_accept, a_move, b_move, a_free, b_free, out_free;

  // Stage A: accepted word and key compare.
  in_word_t          a_word_r;
  logic [63:0]       key_r [ENTRIES];
  logic [ENTRIES-1:0] valid_r;
  logic [ENTRIES-1:0] match_vec;
  logic              a_hit, a_free_found, a_claim;
  logic [IDX_W-1:0]  hit_idx, free_idx, a_slot;
  status_t           a_status;
  logic [63:0]       a_prod;

  // Stage B: totals update.
  status_t           b_status_r;
  opcode_t           b_op_r;
  logic [IDX_W-1:0]  b_slot_r;
  logic [63:0]       b_prod_r;
  logic [31:0]       b_qty_r;
  logic              b_fwd_r;
  logic [IDX_W-1:0]  fwd_slot_r;
  row_t              fwd_row_r;
  logic [ROW_W-1:0]  ram_rd;
  row_t              old_row, new_row;
  logic [64:0]       sum_ext, qty_ext;
  logic              b_wr_en;
  out_word_t         b_result;
  out_word_t         out_word_r;

  // Handshake and stage movement.
  always_comb begin
    out_free  = !out_valid_r || !out_stall;
    b_move    = b_valid_r && out_free;
    b_free    = !b_valid_r || out_free;
    a_move    = a_valid_r && b_free;
    a_free    = !a_valid_r || b_free;
    in_accept = in_valid && a_free;

    a_valid_nxt   = in_accept ? 1'b1 : (a_move ? 1'b0 : a_valid_r);
    b_valid_nxt   = a_move ? 1'b1 : (b_move ? 1'b0 : b_valid_r);
    out_valid_nxt = b_move ? 1'b1 : (out_free ? 1'b0 : out_valid_r);
  end

  assign in_stall  = !a_free;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      b_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
      b_fwd_r     <= 1'b0;
    end else begin
      a_valid_r   <= a_valid_nxt;
      b_valid_r   <= b_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (a_move) begin
        b_fwd_r <= b_wr_en;
      end
    end
  end

  // Stage A: compare the symbol against every valid row, pick lowest free row.
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      match_vec[i] = valid_r[i] && (key_r[i] == a_word_r.symbol);
    end
    hit_idx  = '0;
    free_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (match_vec[i]) begin
        hit_idx = IDX_W'(i);
      end
      if (!valid_r[i]) begin
        free_idx = IDX_W'(i);
      end
    end
    a_hit        = |match_vec;
    a_free_found = !(&valid_r);

    if (a_word_r.opcode == OP_QUERY) begin
      a_status = a_hit ? ST_HIT : ST_MISS;
    end else if (a_hit) begin
      a_status = ST_HIT;
    end else begin
      a_status = a_free_found ? ST_NEW : ST_FULL;
    end
    a_slot  = a_hit ? hit_idx : free_idx;
    a_claim = a_move && (a_status == ST_NEW);
    a_prod  = 64'(a_word_r.price) * 64'(a_word_r.quantity);
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      a_word_r <= in_word;
    end
    if (a_move) begin
      b_status_r <= a_status;
      b_op_r     <= a_word_r.opcode;
      b_slot_r   <= a_slot;
      b_prod_r   <= a_prod;
      b_qty_r    <= a_word_r.quantity;
    end
    if (a_claim) begin
      key_r[free_idx] <= a_word_r.symbol;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (a_claim) begin
      valid_r[free_idx] <= 1'b1;
    end
  end

  vwap_ram #(
    .WIDTH (ROW_W),
    .DEPTH (ENTRIES)
  ) u_totals_ram (
    .clk     (clk),
    .wr_en   (b_wr_en),
    .wr_addr (b_slot_r),
    .wr_data (new_row),
    .rd_en   (a_move),
    .rd_addr (a_slot),
    .rd_data (ram_rd)
  );

  // Stage B: take the row written on the same edge as our read from the bypass.
  always_comb begin
    old_row = (b_fwd_r && (fwd_slot_r == b_slot_r)) ? fwd_row_r : row_t'(ram_rd);
    sum_ext = {1'b0, old_row.sum} + {1'b0, b_prod_r};
    qty_ext = {1'b0, old_row.qty} + {33'd0, b_qty_r};

    new_row = old_row;
    if (b_status_r == ST_NEW) begin
      new_row.sum = b_prod_r;
      new_row.qty = {32'd0, b_qty_r};
      new_row.cnt = 32'd1;
    end else if (b_op_r == OP_TRADE) begin
      new_row.sum = sum_ext[64] ? '1 : sum_ext[63:0];
      new_row.qty = qty_ext[64] ? '1 : qty_ext[63:0];
      new_row.cnt = (&old_row.cnt) ? old_row.cnt : old_row.cnt + 32'd1;
    end

    b_wr_en = b_move && (b_op_r == OP_TRADE) &&
              ((b_status_r == ST_HIT) || (b_status_r == ST_NEW));

    b_result.status = b_status_r;
    if ((b_status_r == ST_HIT) || (b_status_r == ST_NEW)) begin
      b_result.sum_price_qty = new_row.sum;
      b_result.total_qty     = new_row.qty;
      b_result.trade_count   = new_row.cnt;
      b_result.saturated     = (&new_row.sum) || (&new_row.qty) || (&new_row.cnt);
    end else begin
      b_result.sum_price_qty = '0;
      b_result.total_qty     = '0;
      b_result.trade_count   = '0;
      b_result.saturated     = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_wr_en) begin
      fwd_slot_r <= b_slot_r;
      fwd_row_r  <= new_row;
    end
    if (b_move) begin
      out_word_r <= b_result;
    end
  end

`ifndef SYNTHESIS
  // Rows are only ever claimed, never released.
  a_valid_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> ((valid_r & $past(valid_r)) == $past(valid_r)))
    else $error("valid row was dropped");

  // A symbol lives in at most one row.
  a_key_unique: assert property (@(posedge clk) disable iff (!rst_n)
    a_valid_r |-> $onehot0(match_vec))
    else $error("symbol matches more than one row");

  // Table full only when every row is in use.
  a_full_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (a_valid_r && (a_status == ST_FULL)) |-> (&valid_r))
    else $error("table full reported with a free row");
`endif

endmodule

// ===== bench/per_symbol_vwap_checker.sv =====
// Watches both channels of the VWAP accumulator, predicts each result word and compares it.
module per_symbol_vwap_checker
  import vwap_pkg::*;
#(
  parameter int ENTRIES = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_word_t  in_word,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_word_t out_word,
  output int        fail_count,
  output int        pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [63:0] TOTAL_MAX = '1;
  localparam logic [31:0] COUNT_MAX = '1;

  // Shadow copy of the symbol table
  logic [63:0] row_key [ENTRIES];
  bit          row_live[ENTRIES];
  logic [63:0] row_sum [ENTRIES];
  logic [63:0] row_qty [ENTRIES];
  logic [31:0] row_cnt [ENTRIES];

  out_word_t due_totals[$];

  function automatic logic [63:0] add_clamped(logic [63:0] a, logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? TOTAL_MAX : s[63:0];
  endfunction

  // Result word for a row; a negative slot means no row (all totals zero).
  function automatic out_word_t row_report(status_t st, int slot);
    out_word_t r;
    r = '0;
    r.status = st;
    if (slot >= 0) begin
      r.sum_price_qty = row_sum[slot];
      r.total_qty     = row_qty[slot];
      r.trade_count   = row_cnt[slot];
      r.saturated     = (row_sum[slot] == TOTAL_MAX) || (row_qty[slot] == TOTAL_MAX) ||
                        (row_cnt[slot] == COUNT_MAX);
    end
    return r;
  endfunction

  function automatic out_word_t apply_vwap_word(in_word_t w);
    int          hit;
    int          free_slot;
    logic [63:0] product;
    hit       = -1;
    free_slot = -1;
    product   = 64'(w.price) * 64'(w.quantity);
    for (int i = 0; i < ENTRIES; i++) begin
      if (row_live[i]) begin
        if (hit < 0 && row_key[i] == w.symbol) hit = i;
      end else if (free_slot < 0) begin
        free_slot = i;
      end
    end
    if (w.opcode == OP_QUERY) begin
      if (hit < 0) return row_report(ST_MISS, -1);
      return row_report(ST_HIT, hit);
    end
    if (hit >= 0) begin
      row_sum[hit] = add_clamped(row_sum[hit], product);
      row_qty[hit] = add_clamped(row_qty[hit], 64'(w.quantity));
      if (row_cnt[hit] != COUNT_MAX) row_cnt[hit] = row_cnt[hit] + 1;
      return row_report(ST_HIT, hit);
    end
    // Drop the trade when no row is free
    if (free_slot < 0) return row_report(ST_FULL, -1);
    row_key[free_slot]  = w.symbol;
    row_live[free_slot] = 1'b1;
    row_sum[free_slot]  = product;
    row_qty[free_slot]  = 64'(w.quantity);
    row_cnt[free_slot]  = 32'd1;
    return row_report(ST_NEW, free_slot);
  endfunction

  function automatic int field_off(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin : watch
    int        errs;
    out_word_t want;
    errs = 0;
    if (!rst_n) begin
      for (int i = 0; i < ENTRIES; i++) row_live[i] = 1'b0;
      due_totals.delete();
    end else begin
      // Check the result side first so a word accepted this edge cannot mask a stray result
      if (out_valid && !out_stall) begin
        if (due_totals.size() == 0) begin
          $display("%0t: result word with none expected, expected none, actual %h",
                   $time, out_word);
          errs++;
        end else begin
          want = due_totals.pop_front();
          errs += field_off("status", 64'(want.status), 64'(out_word.status));
          errs += field_off("sum_price_qty", want.sum_price_qty, out_word.sum_price_qty);
          errs += field_off("total_qty", want.total_qty, out_word.total_qty);
          errs += field_off("trade_count", 64'(want.trade_count), 64'(out_word.trade_count));
          errs += field_off("saturated", 64'(want.saturated), 64'(out_word.saturated));
        end
      end
      if (in_valid && !in_stall) due_totals.push_back(apply_vwap_word(in_word));
    end
    fail_count <= fail_count + errs;
    pending    <= due_totals.size();
  end

endmodule

// ===== bench/tb_per_symbol_vwap_accumulator_top.sv =====
// Stimulus and verdict for the per-symbol VWAP accumulator.
module tb_per_symbol_vwap_accumulator_top;
  timeunit 1ns;
  timeprecision 1ps;
  import vwap_pkg::*;

  localparam int ENTRIES      = 64;
  localparam int RANDOM_ITEMS = 1600;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int SETTLE       = 12;
  localparam int POOL_CAP     = 96;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  in_word_t  in_word   = '0;
  logic      out_stall = 1'b0;
  logic      in_stall;
  logic      out_valid;
  out_word_t out_word;
  int        fail_count;
  int        pending;
  int        cycles    = 0;

  logic [63:0] known_syms[$];
  int          tx_calm   = 0;
  int          rx_calm   = 0;
  int          rx_hold   = 0;
  logic        out_taken = 1'b0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  per_symbol_vwap_accumulator_top #(.ENTRIES(ENTRIES)) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word (out_word)
  );

  per_symbol_vwap_checker #(.ENTRIES(ENTRIES)) u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .fail_count(fail_count),
    .pending   (pending)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_per_symbol_vwap_accumulator_top NOT OK");
      $finish;
    end
  end

  // Result side: after each accepted word, hold stall for a random number of cycles
  always @(posedge clk) out_taken <= rst_n && out_valid && !out_stall;

  always @(negedge clk) begin
    if (out_taken) begin
      if (rx_calm > 0) begin
        rx_calm--;
        rx_hold = 0;
      end else begin
        rx_hold = $urandom_range(0, 14);
        if ($urandom_range(0, 15) == 0) rx_calm = $urandom_range(20, 60);
      end
    end
    if (rx_hold > 0) begin
      out_stall <= 1'b1;
      rx_hold--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic send_word(input in_word_t w);
    int gap;
    if (tx_calm > 0) begin
      tx_calm--;
      gap = 0;
    end else begin
      gap = $urandom_range(0, 14);
      if ($urandom_range(0, 15) == 0) tx_calm = $urandom_range(20, 60);
    end
    repeat (gap) @(negedge clk) in_valid <= 1'b0;
    @(negedge clk);
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic post_word(input opcode_t op, input logic [63:0] sym,
                           input logic [31:0] price, input logic [31:0] qty);
    in_word_t w;
    bit       seen;
    w.opcode   = op;
    w.symbol   = sym;
    w.price    = price;
    w.quantity = qty;
    send_word(w);
    seen = 1'b0;
    foreach (known_syms[i]) if (known_syms[i] == sym) seen = 1'b1;
    if (op == OP_TRADE && !seen && known_syms.size() < POOL_CAP) known_syms.push_back(sym);
  endtask

  // Idle the sender until every expected result has come back
  task automatic drain_results();
    @(negedge clk) in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  function automatic logic [63:0] fresh_symbol();
    return {$urandom, $urandom};
  endfunction

  initial begin : stimulus
    int          pick;
    logic [31:0] price;
    logic [31:0] qty;
    logic [63:0] sym;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty table, extreme keys and values, saturation, misses
    post_word(OP_QUERY, 64'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    post_word(OP_TRADE, 64'd0, 32'd0, 32'd0);
    post_word(OP_TRADE, '1, '1, '1);
    post_word(OP_TRADE, '1, '1, '1);
    post_word(OP_QUERY, '1, 32'd0, 32'd0);
    post_word(OP_TRADE, '1, 32'd0, 32'd0);
    post_word(OP_TRADE, '1, 32'd7, 32'd3);
    post_word(OP_TRADE, 64'd0, '1, 32'd1);
    post_word(OP_TRADE, 64'd0, 32'd1, '1);
    post_word(OP_QUERY, 64'd0, 32'h5A5A_5A5A, 32'hA5A5_A5A5);
    post_word(OP_QUERY, 64'h0123_4567_89AB_CDEF, '1, 32'd0);
    post_word(OP_TRADE, 64'h8000_0000_0000_0000, 32'h8000_0000, 32'd2);
    post_word(OP_TRADE, 64'h8000_0000_0000_0000, 32'h8000_0000, 32'd2);
    post_word(OP_TRADE, 64'd1, 32'd0, '1);
    post_word(OP_QUERY, 64'd1, 32'd0, 32'd0);
    post_word(OP_QUERY, 64'h8000_0000_0000_0000, 32'd0, 32'd0);
    post_word(OP_TRADE, 64'h5555_5555_5555_5555, 32'h5555_5555, 32'hAAAA_AAAA);
    post_word(OP_TRADE, 64'hAAAA_AAAA_AAAA_AAAA, 32'hAAAA_AAAA, 32'h5555_5555);
    drain_results();

    // Random: mostly traffic on known symbols, with fresh symbols filling the table
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 2) drain_results();
      if ($urandom_range(0, 9) == 0) begin
        price = $urandom;
        qty   = $urandom;
      end else if ($urandom_range(0, 49) == 0) begin
        price = '1;
        qty   = '1;
      end else begin
        price = $urandom_range(1, 100000);
        qty   = $urandom_range(0, 10000);
      end
      pick = $urandom_range(0, 99);
      sym  = (pick < 80) ? known_syms[$urandom_range(0, known_syms.size() - 1)]
                         : fresh_symbol();
      if (pick < 55 || (pick >= 80 && pick < 92)) post_word(OP_TRADE, sym, price, qty);
      else post_word(OP_QUERY, sym, price, qty);
    end

    drain_results();
    repeat (SETTLE) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_per_symbol_vwap_accumulator_top OK");
    end else begin
      $display("tb_per_symbol_vwap_accumulator_top NOT OK");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/vwap_pkg.sv
hdl/vwap_ram.sv
hdl/per_symbol_vwap_accumulator_top.sv
bench/per_symbol_vwap_checker.sv
bench/tb_per_symbol_vwap_accumulator_top.sv
